FILE: src/lspp_pkg.sv
`default_nettype none

package lspp_pkg;

    // Field widths
    localparam int OP_W      = 2;
    localparam int IDX_W     = 4;
    localparam int VAL_W     = 32;
    localparam int BEAM_W    = 10;
    localparam int RANGE_W   = 24;
    localparam int REFL_W    = 16;
    localparam int POINT_W   = 32;
    localparam int START_W   = 22;
    localparam int STEP_W    = 21;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 22;

    localparam int BEAMS_PER_SCAN = 541;
    localparam int ENTRY_COUNT    = 12;
    localparam int CORDIC_STEPS   = 16;

    localparam logic signed [31:0] Q_ONE = 32'sd65536;

    // Angle reduction, Q16.16 radians
    localparam logic [18:0]        TWO_PI_U   = 19'd411775;
    localparam logic signed [20:0] TWO_PI_S   = 21'sd411775;
    localparam logic signed [20:0] PI_S       = 21'sd205887;
    localparam logic signed [20:0] HALF_PI_S  = 21'sd102944;
    // floor(2^40 / 2pi) in Q16.16 units; quotient estimate is exact or one low
    localparam logic [21:0]        RECIP_2PI  = 22'd2670175;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [15:0] ATAN_Q16 [0:CORDIC_STEPS-1] = '{
        16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
        16'd256,   16'd128,   16'd64,    16'd32,   16'd16,   16'd8,    16'd4,    16'd2
    };

    // Pipeline register positions
    localparam int ST_PROD   = 0;
    localparam int ST_ABS    = 1;
    localparam int ST_RECIP  = 2;
    localparam int ST_QUOT   = 3;
    localparam int ST_REM    = 4;
    localparam int ST_FOLD   = 5;
    localparam int ST_SIGN   = ST_FOLD + CORDIC_STEPS + 1;
    localparam int ST_RMUL   = ST_SIGN + 1;
    localparam int ST_PLANAR = ST_SIGN + 2;
    localparam int ST_CMUL   = ST_SIGN + 3;
    localparam int ST_CSUM   = ST_SIGN + 4;
    localparam int ST_CAL    = ST_SIGN + 5;
    localparam int ST_PMUL   = ST_SIGN + 6;
    localparam int ST_PHALF  = ST_SIGN + 7;
    localparam int ST_PACC   = ST_SIGN + 8;
    localparam int ST_OUT    = ST_SIGN + 9;
    localparam int N_STAGES  = ST_OUT + 1;

    typedef enum logic [OP_W-1:0] {
        OP_POSE  = 2'd0,
        OP_CALIB = 2'd1,
        OP_BEAM  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_BEAM  = 2'd0,
        KIND_POSE  = 2'd1,
        KIND_CALIB = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ANGLE = 2'd0,
        CFG_ANGLE_STEP = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   idx;
        logic [VAL_W-1:0]   val;
        logic [REFL_W-1:0]  refl;
        logic [RANGE_W-1:0] range;
    } t_meta;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: src/lspp_ifs.sv
`default_nettype none

interface lspp_beam_if;
    logic                                  valid;
    logic                                  ready;
    logic [lspp_pkg::OP_W-1:0]             operation;
    logic [lspp_pkg::IDX_W-1:0]            entry_index;
    logic signed [lspp_pkg::VAL_W-1:0]     entry_value;
    logic [lspp_pkg::BEAM_W-1:0]           beam_index;
    logic [lspp_pkg::RANGE_W-1:0]          beam_range;
    logic [lspp_pkg::REFL_W-1:0]           beam_reflectance;

    modport source (output valid, operation, entry_index, entry_value, beam_index,
                    beam_range, beam_reflectance, input ready);
    modport sink   (input valid, operation, entry_index, entry_value, beam_index,
                    beam_range, beam_reflectance, output ready);
endinterface

interface lspp_point_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lspp_pkg::POINT_W-1:0]   point_x;
    logic signed [lspp_pkg::POINT_W-1:0]   point_y;
    logic signed [lspp_pkg::POINT_W-1:0]   point_z;
    logic [lspp_pkg::REFL_W-1:0]           point_reflectance;

    modport source (output valid, point_x, point_y, point_z, point_reflectance, input ready);
    modport sink   (input valid, point_x, point_y, point_z, point_reflectance, output ready);
endinterface

interface lspp_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [lspp_pkg::CFG_IDX_W-1:0]        index;
    logic [lspp_pkg::CFG_DAT_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/lidar_scan_point_projector.sv
`default_nettype none

// Channel   | Dir | Word
// ----------+-----+---------------------------------------------------------
// i_beam    | in  | operation, entry_index, entry_value, beam_index/range/refl
// o_point   | out | point_x, point_y, point_z, point_reflectance
// i_cfg     | in  | index (0 base angle, 1 angle_step), data; always ready
//
// One word per cycle in, one per cycle out while the output is taken; from
// accept to the output register the pipe holds the angle reduction, the
// 16-stage CORDIC, and the calibration and pose matrix stages.
// All stages advance together; a full output register not taken stalls
// the whole pipe and drops i_beam.ready, nothing is lost or repeated.
// Matrix writes travel down the pipe and land at the stage that reads the
// matrix, so each beam sees exactly the writes accepted before it.
// Synchronous active-low reset empties the pipe and restores identity
// matrices and default angles.

module lidar_scan_point_projector (
    input  wire             i_clk,
    input  wire             i_rst_n,
    lspp_beam_if.sink       i_beam,
    lspp_cfg_if.sink        i_cfg,
    lspp_point_if.source    o_point
);

    localparam int NS = lspp_pkg::N_STAGES;
    localparam int CS = lspp_pkg::CORDIC_STEPS;

    logic en;

    // configuration
    logic [lspp_pkg::START_W-1:0] r_base_angle;
    logic [lspp_pkg::STEP_W-1:0]  r_angle_step;

    // matrices
    logic signed [31:0] r_pose  [0:lspp_pkg::ENTRY_COUNT-1];
    logic signed [31:0] r_calib [0:lspp_pkg::ENTRY_COUNT-1];

    // control pipe
    logic               r_vld  [0:NS-1];
    lspp_pkg::t_meta    r_meta [0:NS-1];
    lspp_pkg::t_meta    n_meta;
    logic               n_keep;

    // angle reduction
    logic [30:0]        r_prod;
    logic signed [31:0] n_angle;
    logic [30:0]        r_abs1, r_abs2, r_abs3;
    logic               r_neg1, r_neg2, r_neg3;
    logic [52:0]        r_recip;
    logic [30:0]        r_qc;
    logic [30:0]        n_diff;
    logic [19:0]        n_rem;
    logic signed [20:0] r_zr;
    logic signed [20:0] n_zf;
    logic               n_flip;

    // CORDIC
    logic signed [33:0] r_cx   [0:CS];
    logic signed [33:0] r_cy   [0:CS];
    logic signed [19:0] r_cz   [0:CS-1];
    logic               r_flip [0:CS];

    // planar point
    logic signed [31:0] r_cos, r_sin;
    logic signed [56:0] r_mx, r_my;
    logic signed [56:0] n_px, n_py;
    logic signed [26:0] r_px, r_py;

    // calibration and pose
    logic signed [58:0] r_cp0 [0:3];
    logic signed [58:0] r_cp1 [0:3];
    logic signed [31:0] r_c3a [0:3];
    logic signed [31:0] r_c3b [0:3];
    logic signed [59:0] r_cs  [0:3];
    logic signed [63:0] n_vt  [0:3];
    logic signed [31:0] r_v   [0:3];
    logic signed [63:0] r_pp  [0:2][0:3];
    logic signed [63:0] r_ph0 [0:2];
    logic signed [63:0] r_ph1 [0:2];
    logic signed [63:0] r_pa  [0:2];
    logic signed [31:0] r_out [0:2];

    // ---------------- handshakes ----------------
    assign en            = !o_point.valid || o_point.ready;
    assign i_beam.ready  = en;
    assign i_cfg.ready   = 1'b1;

    assign o_point.valid             = r_vld[lspp_pkg::ST_OUT]
                                       && (r_meta[lspp_pkg::ST_OUT].kind == lspp_pkg::KIND_BEAM);
    assign o_point.point_x           = r_out[0];
    assign o_point.point_y           = r_out[1];
    assign o_point.point_z           = r_out[2];
    assign o_point.point_reflectance = r_meta[lspp_pkg::ST_OUT].refl;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_angle <= lspp_pkg::START_W'(-205887);
            r_angle_step <= lspp_pkg::STEP_W'(572);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                lspp_pkg::CFG_BASE_ANGLE: r_base_angle <= i_cfg.data;
                lspp_pkg::CFG_ANGLE_STEP: r_angle_step <= i_cfg.data[lspp_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- entry decode ----------------
    // Dropped at entry: unused op, out-of-range entry, zero range, beam past scan.
    always_comb begin
        n_meta.kind  = lspp_pkg::KIND_BEAM;
        n_meta.idx   = i_beam.entry_index;
        n_meta.val   = i_beam.entry_value;
        n_meta.refl  = i_beam.beam_reflectance;
        n_meta.range = i_beam.beam_range;
        n_keep       = 1'b0;
        unique case (i_beam.operation)
            lspp_pkg::OP_POSE: begin
                n_meta.kind = lspp_pkg::KIND_POSE;
                n_keep      = i_beam.entry_index < lspp_pkg::IDX_W'(lspp_pkg::ENTRY_COUNT);
            end
            lspp_pkg::OP_CALIB: begin
                n_meta.kind = lspp_pkg::KIND_CALIB;
                n_keep      = i_beam.entry_index < lspp_pkg::IDX_W'(lspp_pkg::ENTRY_COUNT);
            end
            lspp_pkg::OP_BEAM: begin
                n_keep = (i_beam.beam_range != '0)
                         && (i_beam.beam_index < lspp_pkg::BEAM_W'(lspp_pkg::BEAMS_PER_SCAN));
            end
            default: n_keep = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_beam.valid && n_keep;
            for (int k = 1; k < NS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_meta[0] <= n_meta;
            for (int k = 1; k < NS; k++) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    // ---------------- angle and reduction mod 2pi ----------------
    assign n_angle = $signed({{(32-lspp_pkg::START_W){r_base_angle[lspp_pkg::START_W-1]}},
                              r_base_angle}) + $signed({1'b0, r_prod});
    assign n_diff  = r_abs3 - r_qc;

    always_comb begin
        n_rem = n_diff[19:0];
        if (n_rem >= 20'(lspp_pkg::TWO_PI_U)) begin
            n_rem = n_rem - 20'(lspp_pkg::TWO_PI_U);
        end
    end

    // fold into [-pi, pi], then into [-pi/2, pi/2] with a sign flip
    always_comb begin
        n_zf   = r_zr;
        n_flip = 1'b0;
        if (n_zf > lspp_pkg::PI_S) begin
            n_zf = n_zf - lspp_pkg::TWO_PI_S;
        end
        if (n_zf < -lspp_pkg::PI_S) begin
            n_zf = n_zf + lspp_pkg::TWO_PI_S;
        end
        if (n_zf > lspp_pkg::HALF_PI_S) begin
            n_zf   = n_zf - lspp_pkg::PI_S;
            n_flip = 1'b1;
        end else if (n_zf < -lspp_pkg::HALF_PI_S) begin
            n_zf   = n_zf + lspp_pkg::PI_S;
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod    <= 31'(i_beam.beam_index) * 31'(r_angle_step);
            r_neg1    <= n_angle[31];
            r_abs1    <= n_angle[31] ? 31'(-n_angle) : n_angle[30:0];
            r_recip   <= 53'(r_abs1) * 53'(lspp_pkg::RECIP_2PI);
            r_abs2    <= r_abs1;
            r_neg2    <= r_neg1;
            r_qc      <= 31'(r_recip[52:40]) * 31'(lspp_pkg::TWO_PI_U);
            r_abs3    <= r_abs2;
            r_neg3    <= r_neg2;
            // truncating remainder keeps the dividend's sign
            r_zr      <= r_neg3 ? -$signed({1'b0, n_rem}) : $signed({1'b0, n_rem});
            r_cz[0]   <= n_zf[19:0];
            r_cx[0]   <= lspp_pkg::CORDIC_GAIN;
            r_cy[0]   <= '0;
            r_flip[0] <= n_flip;
        end
    end

    // ---------------- CORDIC, one iteration per stage ----------------
    for (genvar i = 0; i < CS; i++) begin : g_cordic
        logic signed [33:0] dx, dy;
        logic               dir;
        assign dx  = r_cy[i] >>> i;
        assign dy  = r_cx[i] >>> i;
        assign dir = !r_cz[i][19];

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cx[i+1]   <= dir ? r_cx[i] - dx : r_cx[i] + dx;
                r_cy[i+1]   <= dir ? r_cy[i] + dy : r_cy[i] - dy;
                r_flip[i+1] <= r_flip[i];
            end
        end

        if (i < CS - 1) begin : g_z
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_cz[i+1] <= dir ? r_cz[i] - $signed({4'b0, lspp_pkg::ATAN_Q16[i]})
                                     : r_cz[i] + $signed({4'b0, lspp_pkg::ATAN_Q16[i]});
                end
            end
        end
    end

    // ---------------- planar point ----------------
    assign n_px = (r_mx + 57'sd536870912) >>> 30;
    assign n_py = (r_my + 57'sd536870912) >>> 30;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cos <= r_flip[CS] ? 32'(-r_cx[CS]) : 32'(r_cx[CS]);
            r_sin <= r_flip[CS] ? 32'(-r_cy[CS]) : 32'(r_cy[CS]);
            r_mx  <= 57'($signed({1'b0, r_meta[lspp_pkg::ST_SIGN].range})) * 57'(r_cos);
            r_my  <= 57'($signed({1'b0, r_meta[lspp_pkg::ST_SIGN].range})) * 57'(r_sin);
            r_px  <= n_px[26:0];
            r_py  <= n_py[26:0];
        end
    end

    // ---------------- calibration ----------------
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_vt[r] = 64'(r_cs[r] >>> 16) + 64'(r_c3b[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                r_cp0[r] <= 59'(r_calib[r*3])   * 59'(r_px);
                r_cp1[r] <= 59'(r_calib[r*3+1]) * 59'(r_py);
                r_c3a[r] <= r_calib[r*3+2];
                r_cs[r]  <= 60'(r_cp0[r]) + 60'(r_cp1[r]) + 60'sd32768;
                r_c3b[r] <= r_c3a[r];
                r_v[r]   <= lspp_pkg::sat32(n_vt[r]);
            end
        end
    end

    // ---------------- pose ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 4; k++) begin
                    r_pp[r][k] <= 64'(r_pose[r*4+k]) * 64'(r_v[k]);
                end
                r_ph0[r] <= (r_pp[r][0] >>> 2) + (r_pp[r][1] >>> 2);
                r_ph1[r] <= (r_pp[r][2] >>> 2) + (r_pp[r][3] >>> 2);
                r_pa[r]  <= r_ph0[r] + r_ph1[r] + 64'sd8192;
                r_out[r] <= lspp_pkg::sat32(r_pa[r] >>> 14);
            end
        end
    end

    // ---------------- matrix writes, applied where each matrix is read ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < lspp_pkg::ENTRY_COUNT; e++) begin
                r_pose[e]  <= (e == 0 || e == 5 || e == 10) ? lspp_pkg::Q_ONE : '0;
                r_calib[e] <= (e == 0 || e == 4 || e == 11) ? lspp_pkg::Q_ONE : '0;
            end
        end else if (en) begin
            if (r_vld[lspp_pkg::ST_PLANAR]
                && r_meta[lspp_pkg::ST_PLANAR].kind == lspp_pkg::KIND_CALIB) begin
                r_calib[r_meta[lspp_pkg::ST_PLANAR].idx] <= r_meta[lspp_pkg::ST_PLANAR].val;
            end
            if (r_vld[lspp_pkg::ST_CAL]
                && r_meta[lspp_pkg::ST_CAL].kind == lspp_pkg::KIND_POSE) begin
                r_pose[r_meta[lspp_pkg::ST_CAL].idx] <= r_meta[lspp_pkg::ST_CAL].val;
            end
        end
    end

    // ---------------- assertions ----------------
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_point.valid && !o_point.ready) |-> !i_beam.ready)
        else $error("input accepted while output stalled");

    a_rem_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[lspp_pkg::ST_REM] |-> (r_zr < lspp_pkg::TWO_PI_S && r_zr > -lspp_pkg::TWO_PI_S))
        else $error("angle remainder out of range");

    a_fold_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[lspp_pkg::ST_FOLD] |-> (r_cz[0] <= 20'(lspp_pkg::HALF_PI_S)
                                      && r_cz[0] >= -20'(lspp_pkg::HALF_PI_S)))
        else $error("folded angle outside half pi");

    a_pipe_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en |=> (r_vld[lspp_pkg::ST_OUT] == $past(r_vld[lspp_pkg::ST_PACC])))
        else $error("pipeline valid lost or duplicated");

endmodule

`default_nettype wire
